// ===== rtl/keyed_priority_fifo_unit_macros.svh =====
// assertion helpers used by the checker file
`ifndef KEYED_PRIORITY_FIFO_UNIT_MACROS_SVH
`define KEYED_PRIORITY_FIFO_UNIT_MACROS_SVH

// same-cycle implication, idle during reset
`define KPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed priority fifo: same-cycle check failed");

// next-cycle implication, idle during reset
`define KPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed priority fifo: next-cycle check failed");

`endif

// ===== rtl/kpf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kpf_pkg;

    localparam int unsigned ID_W  = 32;
    localparam int unsigned CMD_W = 2;
    localparam int unsigned ST_W  = 2;
    localparam int unsigned POS_W = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SERVE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SERVE_PR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd3;

    // status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_DUP  = 2'd1;
    localparam logic [ST_W-1:0] ST_NONE = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL = 2'd3;

    // input beat
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  ident;
        logic             flag;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [ID_W-1:0]  removed_ident;
        logic [POS_W-1:0] position;
    } t_out_beat;

    // controller to datapath commands
    typedef struct packed {
        logic start;
        logic scan;
        logic shift;
        logic append;
        logic remove_done;
        logic set_dup;
        logic set_none;
        logic set_full;
        logic load_out;
    } t_ctl;

    // datapath to controller status
    typedef struct packed {
        logic found;
        logic not_found;
        logic shift_done;
        logic is_add;
        logic full;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/keyed_priority_fifo_unit.sv =====
// channel   direction   handshake                 beat
// in        to block    i_in_valid / o_in_ready   cmd, ident, flag
// out       from block  o_out_valid / i_out_ready status, removed_ident, position
//
// one command at a time; how long a command takes is set by the
// single read port of the entry RAM (scan one entry a cycle, then shift the tail down)
// serve head finds its entry at once and spends its time closing the gap
// synchronous active-low reset empties the queue; no clearing pass of the RAM
// a waiting result holds in the output register; the next command is taken meanwhile
`timescale 1ns / 1ps
`default_nettype none

module keyed_priority_fifo_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire kpf_pkg::t_in_beat  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output kpf_pkg::t_out_beat      o_out_data
);

    import kpf_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // sequencer
    kpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    // queue store and pointers
    kpf_datapath #(
        .DEPTH(DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_data (i_in_data),
        .i_ctl     (ctl),
        .o_sts     (sts),
        .o_out_data(o_out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/kpf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kpf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kpf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kpf_datapath #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire kpf_pkg::t_in_beat i_in_data,
    input  wire kpf_pkg::t_ctl     i_ctl,
    output kpf_pkg::t_sts          o_sts,
    output kpf_pkg::t_out_beat     o_out_data
);

    import kpf_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned EW = ID_W + 1;

    // captured command
    logic [CMD_W-1:0] r_cmd;
    logic [ID_W-1:0]  r_id;
    logic             r_flag;

    // queue length and scan pointers
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_rd;
    logic [CW-1:0] r_wr;
    logic          r_pend;

    // result staging and output register
    logic [ID_W-1:0] r_rem;
    t_out_beat       r_res;
    t_out_beat       r_out;

    logic            issue;
    logic            match;
    logic            hit;
    logic [EW-1:0]   rd_data;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [EW-1:0]   wr_data;
    logic [31:0]     len_next;

    // entry store: flag above identifier
    kpf_ram #(
        .WIDTH(EW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (issue),
        .i_rd_addr(r_rd[AW-1:0]),
        .o_rd_data(rd_data)
    );

    // one read a cycle while walking the queue
    assign issue = (i_ctl.scan | i_ctl.shift) & (r_rd < r_count);

    // match test on the entry that came back
    always_comb begin
        case (r_cmd)
            CMD_SERVE:    match = 1'b1;
            CMD_SERVE_PR: match = rd_data[ID_W];
            default:      match = (rd_data[ID_W-1:0] == r_id);
        endcase
    end

    assign hit = r_pend & match;

    // moved entry goes one slot down, append writes the tail
    assign wr_en   = (i_ctl.shift & r_pend) | i_ctl.append;
    assign wr_addr = i_ctl.append ? r_count[AW-1:0] : r_wr[AW-1:0];
    assign wr_data = i_ctl.append ? {r_flag, r_id} : rd_data;

    assign len_next = 32'(r_count) + 32'd1;

    // status toward the controller
    assign o_sts.found      = hit;
    assign o_sts.not_found  = !hit && (r_rd == r_count);
    assign o_sts.shift_done = (r_rd == r_count) && !r_pend;
    assign o_sts.is_add     = (r_cmd == CMD_ADD);
    assign o_sts.full       = (r_count == CW'(DEPTH));

    // pointers and length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rd    <= '0;
            r_wr    <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_rd   <= '0;
                r_pend <= 1'b0;
            end else if (i_ctl.scan || i_ctl.shift) begin
                r_rd   <= r_rd + CW'(issue);
                r_pend <= issue;
                if (i_ctl.scan && hit) begin
                    r_wr <= r_rd - CW'(1);
                end else if (i_ctl.shift && r_pend) begin
                    r_wr <= r_wr + CW'(1);
                end
            end
            if (i_ctl.append) begin
                r_count <= r_count + CW'(1);
            end else if (i_ctl.remove_done) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // command capture, result staging, output beat
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_cmd  <= i_in_data.cmd;
            r_id   <= i_in_data.ident;
            r_flag <= i_in_data.flag;
        end
        if (i_ctl.scan && hit) begin
            r_rem <= rd_data[ID_W-1:0];
        end
        if (i_ctl.set_dup) begin
            r_res <= '{status: ST_DUP, removed_ident: '0, position: '0};
        end else if (i_ctl.set_none) begin
            r_res <= '{status: ST_NONE, removed_ident: '0, position: '0};
        end else if (i_ctl.set_full) begin
            r_res <= '{status: ST_FULL, removed_ident: '0, position: '0};
        end else if (i_ctl.append) begin
            r_res <= '{status: ST_OK, removed_ident: '0, position: len_next[POS_W-1:0]};
        end else if (i_ctl.remove_done) begin
            r_res <= '{status: ST_OK, removed_ident: r_rem, position: '0};
        end
        if (i_ctl.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

// ===== rtl/kpf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kpf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire kpf_pkg::t_sts i_sts,
    output kpf_pkg::t_ctl      o_ctl
);

    import kpf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_APPEND = 5'b01000,
        S_FIN    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // sequencing of one command
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.found) begin
                    if (i_sts.is_add) begin
                        o_ctl.set_dup = 1'b1;
                        n_state       = S_FIN;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (i_sts.not_found) begin
                    if (!i_sts.is_add) begin
                        o_ctl.set_none = 1'b1;
                        n_state        = S_FIN;
                    end else if (i_sts.full) begin
                        o_ctl.set_full = 1'b1;
                        n_state        = S_FIN;
                    end else begin
                        n_state = S_APPEND;
                    end
                end
            end
            S_SHIFT: begin
                o_ctl.shift = 1'b1;
                if (i_sts.shift_done) begin
                    o_ctl.remove_done = 1'b1;
                    n_state           = S_FIN;
                end
            end
            S_APPEND: begin
                o_ctl.append = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register occupancy
    assign n_out_valid = o_ctl.load_out || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/kpf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_priority_fifo_unit_macros.svh"

module kpf_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               o_in_ready,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_ready,
    input  wire kpf_pkg::t_out_beat o_out_data
);

    import kpf_pkg::*;

    // a stalled result beat stays offered
    `KPF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // an accepted command keeps the block busy for the next cycle
    `KPF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // no result appears the cycle right after a command is taken
    `KPF_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, i_in_valid && o_in_ready && !o_out_valid, !o_out_valid)

    // failed commands carry neither an identifier nor a position
    `KPF_ASSERT_NOW(a_fail_clean, i_clk, i_rst_n, o_out_valid && (o_out_data.status != ST_OK), (o_out_data.removed_ident == '0) && (o_out_data.position == '0))

endmodule

bind keyed_priority_fifo_unit kpf_checker u_kpf_checker (.*);

`default_nettype wire
